[src/ghc_pkg.sv]
`timescale 1ns / 1ps

package ghc_pkg;

    localparam int ORDER_DEFAULT = 8;
    localparam int ELEM_W        = 3;
    localparam int OPCODE_W      = 2;
    localparam int IDX_W         = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_TABLE = 2'd0,
        OP_WRITE_MAP   = 2'd1,
        OP_CHECK       = 2'd2,
        OP_NONE        = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_PAIR,
        ST_READ_IMAGE,
        ST_COMPARE
    } seq_state_t;

    typedef struct packed {
        logic              tbl_we;
        logic              map_we;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } wr_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] tbl_row;
        logic [IDX_W-1:0] tbl_col;
        logic [IDX_W-1:0] map_addr0;
        logic [IDX_W-1:0] map_addr1;
    } rd_req_t;

endpackage

[src/ghc_store.sv]
`timescale 1ns / 1ps

module ghc_store #(
    parameter int ORDER = ghc_pkg::ORDER_DEFAULT
) (
    input  logic                        clk,
    input  ghc_pkg::wr_req_t            wr,
    input  ghc_pkg::rd_req_t            rd,
    output logic [ghc_pkg::ELEM_W-1:0]  tbl_rdata,
    output logic [ghc_pkg::ELEM_W-1:0]  map_rdata0,
    output logic [ghc_pkg::ELEM_W-1:0]  map_rdata1
);

    localparam int CELLS = ORDER * ORDER;
    localparam int AW    = $clog2(CELLS);
    localparam int MW    = $clog2(ORDER);

    logic [ghc_pkg::ELEM_W-1:0] table_mem [CELLS];
    logic [ghc_pkg::ELEM_W-1:0] map_mem   [ORDER];

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr = AW'(int'(wr.row) * ORDER + int'(wr.col));
    assign rd_addr = AW'(int'(rd.tbl_row) * ORDER + int'(rd.tbl_col));

    always_ff @(posedge clk)
    begin
        if (wr.tbl_we)
        begin
            table_mem[wr_addr] <= wr.value;
        end
        tbl_rdata <= table_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.map_we)
        begin
            map_mem[wr.row[MW-1:0]] <= wr.value;
        end
        map_rdata0 <= map_mem[rd.map_addr0[MW-1:0]];
        map_rdata1 <= map_mem[rd.map_addr1[MW-1:0]];
    end

endmodule

[src/ghc_seq.sv]
`timescale 1ns / 1ps

module ghc_seq #(
    parameter int ORDER = ghc_pkg::ORDER_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        check_go,
    input  logic [ghc_pkg::ELEM_W-1:0]  tbl_rdata,
    input  logic [ghc_pkg::ELEM_W-1:0]  map_rdata0,
    input  logic [ghc_pkg::ELEM_W-1:0]  map_rdata1,
    output ghc_pkg::rd_req_t            rd,
    output logic                        busy,
    output logic                        done,
    output logic                        result
);

    localparam int CW = $clog2(ORDER);
    localparam logic [CW-1:0] LAST = CW'(ORDER - 1);

    ghc_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic          done_reg, done_next;
    logic          result_reg, result_next;
    logic          match;
    logic          last_pair;

    assign match     = (tbl_rdata == map_rdata0);
    assign last_pair = (a_reg == LAST) && (b_reg == LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ghc_pkg::ST_IDLE:
            begin
                if (check_go)
                begin
                    state_next = ghc_pkg::ST_READ_PAIR;
                end
            end
            ghc_pkg::ST_READ_PAIR:  state_next = ghc_pkg::ST_READ_IMAGE;
            ghc_pkg::ST_READ_IMAGE: state_next = ghc_pkg::ST_COMPARE;
            ghc_pkg::ST_COMPARE:
            begin
                if (!match || last_pair)
                begin
                    state_next = ghc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ghc_pkg::ST_READ_PAIR;
                end
            end
            default: state_next = ghc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        rd          = '0;
        a_next      = a_reg;
        b_next      = b_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        busy        = (state_reg != ghc_pkg::ST_IDLE);
        unique case (state_reg)
            ghc_pkg::ST_IDLE:
            begin
                if (check_go)
                begin
                    a_next = '0;
                    b_next = '0;
                end
            end
            ghc_pkg::ST_READ_PAIR:
            begin
                // t = table[a][b], ma = map[a], mb = map[b]
                rd.tbl_row   = ghc_pkg::IDX_W'(a_reg);
                rd.tbl_col   = ghc_pkg::IDX_W'(b_reg);
                rd.map_addr0 = ghc_pkg::IDX_W'(a_reg);
                rd.map_addr1 = ghc_pkg::IDX_W'(b_reg);
            end
            ghc_pkg::ST_READ_IMAGE:
            begin
                // table[ma][mb] and map[t]
                rd.tbl_row   = ghc_pkg::IDX_W'(map_rdata0);
                rd.tbl_col   = ghc_pkg::IDX_W'(map_rdata1);
                rd.map_addr0 = ghc_pkg::IDX_W'(tbl_rdata);
            end
            ghc_pkg::ST_COMPARE:
            begin
                if (!match || last_pair)
                begin
                    done_next   = 1'b1;
                    result_next = match;
                end
                else if (b_reg == LAST)
                begin
                    b_next = '0;
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ghc_pkg::ST_IDLE;
            a_reg      <= '0;
            b_reg      <= '0;
            done_reg   <= 1'b0;
            result_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/group_homomorphism_check.sv]
`timescale 1ns / 1ps

// Homomorphism check over a stored Cayley table and element map.
// Input: a word is taken at a rising edge with start high and busy low.
//   opcode selects a table cell write (row, col, value), a map entry
//   write (row, value) or a check run. Writes with an element not below
//   ORDER, and the unused opcode, are dropped.
// Writes leave busy low and give no result.
// A check raises busy and walks every pair (a, b) through a pair read,
// an image read and a compare, using one table read port and two
// map read ports of the on-chip memories. It stops at the first mismatch.
// The next word may be taken once busy drops.
// Output: done pulses for one cycle with is_homomorphism valid. The
// receiver cannot stall; the result is taken in that cycle.
// Reset: control state clears; table and map contents stay undefined
// until written.

module group_homomorphism_check #(
    parameter int ORDER = ghc_pkg::ORDER_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ghc_pkg::OPCODE_W-1:0]  opcode,
    input  logic [ghc_pkg::ELEM_W-1:0]    row,
    input  logic [ghc_pkg::ELEM_W-1:0]    col,
    input  logic [ghc_pkg::ELEM_W-1:0]    value,
    output logic                          done,
    output logic                          is_homomorphism
);

    logic                       accept;
    ghc_pkg::opcode_t           op;
    logic                       row_ok;
    logic                       col_ok;
    logic                       val_ok;
    ghc_pkg::wr_req_t           wr;
    ghc_pkg::rd_req_t           rd;
    logic [ghc_pkg::ELEM_W-1:0] tbl_rdata;
    logic [ghc_pkg::ELEM_W-1:0] map_rdata0;
    logic [ghc_pkg::ELEM_W-1:0] map_rdata1;

    assign accept = start && !busy;
    assign op     = ghc_pkg::opcode_t'(opcode);
    assign row_ok = (int'(row) < ORDER);
    assign col_ok = (int'(col) < ORDER);
    assign val_ok = (int'(value) < ORDER);

    assign wr.tbl_we = accept && (op == ghc_pkg::OP_WRITE_TABLE) && row_ok && col_ok && val_ok;
    assign wr.map_we = accept && (op == ghc_pkg::OP_WRITE_MAP) && row_ok && val_ok;
    assign wr.row    = ghc_pkg::IDX_W'(row);
    assign wr.col    = ghc_pkg::IDX_W'(col);
    assign wr.value  = value;

    ghc_store #(
        .ORDER(ORDER)
    ) u_store (
        .clk        (clk),
        .wr         (wr),
        .rd         (rd),
        .tbl_rdata  (tbl_rdata),
        .map_rdata0 (map_rdata0),
        .map_rdata1 (map_rdata1)
    );

    ghc_seq #(
        .ORDER(ORDER)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .check_go   (accept && (op == ghc_pkg::OP_CHECK)),
        .tbl_rdata  (tbl_rdata),
        .map_rdata0 (map_rdata0),
        .map_rdata1 (map_rdata1),
        .rd         (rd),
        .busy       (busy),
        .done       (done),
        .result     (is_homomorphism)
    );

endmodule

[tb/group_homomorphism_check_tb.sv]
`timescale 1ns / 1ps

module group_homomorphism_check_tb;

    localparam int ORDER       = ghc_pkg::ORDER_DEFAULT;
    localparam int WORD_TARGET = 450;
    localparam int WALK_CYCLES = 3 * ORDER * ORDER + 1;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        ghc_pkg::opcode_t           op;
        logic [ghc_pkg::ELEM_W-1:0] r;
        logic [ghc_pkg::ELEM_W-1:0] c;
        logic [ghc_pkg::ELEM_W-1:0] v;
        bit                         known;
        bit                         want;
    } dir_word_t;

    // Starts from Z8 addition and the identity map.
    localparam dir_word_t DIRECTED [23] = '{
        '{ghc_pkg::OP_CHECK,       3'd0, 3'd0, 3'd0, 1'b1, 1'b1},
        '{ghc_pkg::OP_NONE,        3'd7, 3'd7, 3'd7, 1'b0, 1'b0},
        '{ghc_pkg::OP_CHECK,       3'd7, 3'd7, 3'd7, 1'b1, 1'b1},
        '{ghc_pkg::OP_WRITE_MAP,   3'd0, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd1, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd2, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd3, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd4, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd5, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd6, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd7, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_CHECK,       3'd0, 3'd0, 3'd0, 1'b1, 1'b1},
        '{ghc_pkg::OP_WRITE_MAP,   3'd7, 3'd0, 3'd7, 1'b0, 1'b0},
        '{ghc_pkg::OP_CHECK,       3'd0, 3'd0, 3'd0, 1'b1, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd7, 3'd7, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_TABLE, 3'd7, 3'd7, 3'd7, 1'b0, 1'b0},
        '{ghc_pkg::OP_CHECK,       3'd0, 3'd0, 3'd0, 1'b1, 1'b1},
        '{ghc_pkg::OP_WRITE_TABLE, 3'd0, 3'd0, 3'd7, 1'b0, 1'b0},
        '{ghc_pkg::OP_CHECK,       3'd0, 3'd0, 3'd0, 1'b1, 1'b0},
        '{ghc_pkg::OP_WRITE_TABLE, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_TABLE, 3'd7, 3'd7, 3'd6, 1'b0, 1'b0},
        '{ghc_pkg::OP_WRITE_MAP,   3'd1, 3'd0, 3'd2, 1'b0, 1'b0},
        '{ghc_pkg::OP_CHECK,       3'd0, 3'd0, 3'd0, 1'b0, 1'b0}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [ghc_pkg::OPCODE_W-1:0] opcode;
    logic [ghc_pkg::ELEM_W-1:0]   row;
    logic [ghc_pkg::ELEM_W-1:0]   col;
    logic [ghc_pkg::ELEM_W-1:0]   value;
    logic                         done;
    logic                         is_homomorphism;

    logic [ghc_pkg::ELEM_W-1:0] table_shadow [ORDER][ORDER];
    logic [ghc_pkg::ELEM_W-1:0] map_shadow [ORDER];
    logic [ghc_pkg::ELEM_W-1:0] perm [ORDER];
    logic [ghc_pkg::ELEM_W-1:0] perm_inv [ORDER];
    int                         group_kind;

    bit verdict_q [$];
    int errors;
    int words_sent;
    int checks_seen;
    int homs_seen;
    int reloads;
    int burst_left;
    int idle_cycles;

    group_homomorphism_check #(
        .ORDER(ORDER)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .row(row),
        .col(col),
        .value(value),
        .done(done),
        .is_homomorphism(is_homomorphism)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic bit law_holds();
        logic [ghc_pkg::ELEM_W-1:0] ma;
        logic [ghc_pkg::ELEM_W-1:0] mb;
        for (int a = 0; a < ORDER; a++)
        begin
            ma = map_shadow[a];
            for (int b = 0; b < ORDER; b++)
            begin
                mb = map_shadow[b];
                if (table_shadow[ma][mb] != map_shadow[table_shadow[a][b]])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [ghc_pkg::ELEM_W-1:0] group_product(
        int kind, logic [ghc_pkg::ELEM_W-1:0] a, logic [ghc_pkg::ELEM_W-1:0] b);
        logic [ghc_pkg::ELEM_W-1:0] p;
        if (kind == 0)
            p = a + b;
        else
            p = a ^ b;
        return p;
    endfunction

    // One word; returns after the edge that takes it.
    task automatic issue(ghc_pkg::opcode_t op, logic [ghc_pkg::ELEM_W-1:0] r,
                         logic [ghc_pkg::ELEM_W-1:0] c, logic [ghc_pkg::ELEM_W-1:0] v,
                         bit known, bit want);
        start  <= 1'b1;
        opcode <= op;
        row    <= r;
        col    <= c;
        value  <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (op)
            ghc_pkg::OP_WRITE_TABLE:
                if (r < ORDER && c < ORDER && v < ORDER)
                    table_shadow[r][c] = v;
            ghc_pkg::OP_WRITE_MAP:
                if (r < ORDER && v < ORDER)
                    map_shadow[r] = v;
            ghc_pkg::OP_CHECK:
                verdict_q.push_back(known ? want : law_holds());
            default:
                ;
        endcase
        if (op != ghc_pkg::OP_NONE)
            words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : int'($urandom_range(0, 12));
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    // Full table of Z8 or Z2^3, optionally relabeled by a random permutation.
    task automatic load_group(int kind, bit scramble);
        int                         j;
        logic [ghc_pkg::ELEM_W-1:0] tmp;
        for (int i = 0; i < ORDER; i++)
            perm[i] = ghc_pkg::ELEM_W'(i);
        if (scramble)
            for (int i = ORDER - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
        for (int i = 0; i < ORDER; i++)
            perm_inv[perm[i]] = ghc_pkg::ELEM_W'(i);
        group_kind = kind;
        reloads++;
        for (int a = 0; a < ORDER; a++)
            for (int b = 0; b < ORDER; b++)
                issue(ghc_pkg::OP_WRITE_TABLE, perm[a], perm[b],
                      perm[group_product(kind, ghc_pkg::ELEM_W'(a), ghc_pkg::ELEM_W'(b))],
                      1'b0, 1'b0);
    endtask

    // Writes a homomorphism of the loaded group, sometimes with one entry spoiled, then runs a check.
    task automatic map_episode();
        logic [ghc_pkg::ELEM_W-1:0] img [ORDER];
        logic [ghc_pkg::ELEM_W-1:0] k;
        logic [ghc_pkg::ELEM_W-1:0] c0;
        logic [ghc_pkg::ELEM_W-1:0] c1;
        logic [ghc_pkg::ELEM_W-1:0] c2;
        logic [ghc_pkg::ELEM_W-1:0] x;
        logic [ghc_pkg::ELEM_W-1:0] h;
        k  = ghc_pkg::ELEM_W'($urandom);
        c0 = ghc_pkg::ELEM_W'($urandom);
        c1 = ghc_pkg::ELEM_W'($urandom);
        c2 = ghc_pkg::ELEM_W'($urandom);
        for (int i = 0; i < ORDER; i++)
        begin
            x = perm_inv[i];
            if (group_kind == 0)
                h = k * x;
            else
                h = (x[0] ? c0 : 3'd0) ^ (x[1] ? c1 : 3'd0) ^ (x[2] ? c2 : 3'd0);
            img[i] = perm[h];
        end
        if ($urandom_range(0, 2) == 0)
            img[$urandom_range(0, ORDER - 1)] = ghc_pkg::ELEM_W'($urandom);
        for (int i = 0; i < ORDER; i++)
            issue(ghc_pkg::OP_WRITE_MAP, ghc_pkg::ELEM_W'(i), ghc_pkg::ELEM_W'($urandom),
                  img[i], 1'b0, 1'b0);
        issue(ghc_pkg::OP_CHECK, ghc_pkg::ELEM_W'($urandom), ghc_pkg::ELEM_W'($urandom),
              ghc_pkg::ELEM_W'($urandom), 1'b0, 1'b0);
    endtask

    task automatic noise_episode();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            issue(ghc_pkg::opcode_t'($urandom_range(0, 3)), ghc_pkg::ELEM_W'($urandom),
                  ghc_pkg::ELEM_W'($urandom), ghc_pkg::ELEM_W'($urandom), 1'b0, 1'b0);
        issue(ghc_pkg::OP_CHECK, ghc_pkg::ELEM_W'($urandom), ghc_pkg::ELEM_W'($urandom),
              ghc_pkg::ELEM_W'($urandom), 1'b0, 1'b0);
    endtask

    always @(posedge clk)
    begin : result_monitor
        bit want;
        if (rst_n && done)
        begin
            checks_seen++;
            if (is_homomorphism)
                homs_seen++;
            if (verdict_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual is_homomorphism=%0b",
                         $time, is_homomorphism);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (is_homomorphism !== want)
                begin
                    errors++;
                    $display("%0t: is_homomorphism expected %0b actual %0b",
                             $time, want, is_homomorphism);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int pick;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        opcode      <= ghc_pkg::OP_NONE;
        row         <= '0;
        col         <= '0;
        value       <= '0;
        idle_cycles <= 0;
        errors      = 0;
        words_sent  = 0;
        checks_seen = 0;
        homs_seen   = 0;
        reloads     = 0;
        burst_left  = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every cell and map entry is written before any check
        load_group(0, 1'b0);
        for (int i = 0; i < ORDER; i++)
            issue(ghc_pkg::OP_WRITE_MAP, ghc_pkg::ELEM_W'(i), 3'd0, ghc_pkg::ELEM_W'(i),
                  1'b0, 1'b0);

        foreach (DIRECTED[i])
            issue(DIRECTED[i].op, DIRECTED[i].r, DIRECTED[i].c, DIRECTED[i].v,
                  DIRECTED[i].known, DIRECTED[i].want);
        drain();

        while (words_sent < WORD_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                load_group($urandom_range(0, 1), 1'b1);
            else if (pick < 78)
                map_episode();
            else
                noise_episode();
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (WALK_CYCLES + 8)
            @(posedge clk);

        $display("Sent %0d words, %0d table loads; %0d checks returned, %0d homomorphic.",
                 words_sent, reloads, checks_seen, homs_seen);
        if (errors == 0 && verdict_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/ghc_pkg.sv
src/ghc_store.sv
src/ghc_seq.sv
src/group_homomorphism_check.sv
tb/group_homomorphism_check_tb.sv
